// ----- hdl/hysteresis_thermostat_keypad_entry_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the thermostat keypad block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_THERMOSTAT_KEYPAD_ENTRY_DEFINES_SVH
`define HYSTERESIS_THERMOSTAT_KEYPAD_ENTRY_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define HTKE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define HTKE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/htke_pkg.sv -----
// ----------------------------------------------------------------------------
// htke_pkg
// Types and constants shared by the thermostat keypad entry block.
// ----------------------------------------------------------------------------
`default_nettype none

package htke_pkg;

  // Event kinds carried on the input tuser
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_SWITCH = 2'd1;
  localparam logic [1:0] KIND_KEY    = 2'd2;

  // View modes
  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_TEMP = 2'd2;

  // Key codes
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_STAR       = 4'd14;
  localparam logic [3:0] KEY_HASH       = 4'd15;

  // Entry limits and threshold reset values
  localparam logic [17:0] ENTRY_WRAP_LIMIT = 18'd9999;
  localparam logic [13:0] COMMIT_LIMIT     = 14'd128;
  localparam logic [6:0]  LOW_RESET        = 7'd23;
  localparam logic [6:0]  HIGH_RESET       = 7'd26;

  // Stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 3;

  // One result beat
  typedef struct packed {
    logic signed [14:0] shown_value;
    logic               valve_open;
    logic               pump_running;
    logic [1:0]         view_mode;
    logic               entering;
  } htke_result_t;

endpackage

`default_nettype wire

// ----- hdl/htke_ctrl.sv -----
// ----------------------------------------------------------------------------
// htke_ctrl
// Thermostat state and single-pass event logic: mode, keypad entry,
// thresholds, stored temperature and valve/pump hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

module htke_ctrl
  import htke_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               beat,
  input  wire logic [1:0]         kind,
  input  wire logic [2:0]         switch_mask,
  input  wire logic [3:0]         key_code,
  input  wire logic signed [9:0]  sample,
  output htke_result_t            result
);

  logic              [1:0]  mode, mode_next;
  logic                     entry_active, entry_active_next;
  logic              [13:0] entry_value, entry_value_next;
  logic              [6:0]  low_limit, low_limit_next;
  logic              [6:0]  high_limit, high_limit_next;
  logic signed       [9:0]  current_temp, current_temp_next;
  logic                     valve_flag, valve_flag_next;
  logic                     pump_flag, pump_flag_next;

  logic                     take;
  logic              [13:0] base_value;
  logic              [17:0] digit_value;
  logic signed       [10:0] temp_ext;
  logic signed       [10:0] low_ext;
  logic signed       [10:0] high_ext;

  // Entry value before this key: a fresh entry starts from zero
  assign base_value  = entry_active ? entry_value : 14'd0;
  assign digit_value = {4'd0, base_value} * 18'd10 + {14'd0, key_code};

  // Work out the next state for the event on the input
  always_comb begin
    mode_next         = mode;
    entry_active_next = entry_active;
    entry_value_next  = entry_value;
    low_limit_next    = low_limit;
    high_limit_next   = high_limit;
    current_temp_next = current_temp;
    take              = 1'b0;

    if (entry_active) begin
      take = (kind == KIND_KEY);
    end else begin
      case (kind)
        KIND_SAMPLE: begin
          if (mode == MODE_TEMP) begin
            current_temp_next = sample;
          end
        end
        KIND_SWITCH: begin
          if (switch_mask[0]) begin
            mode_next = MODE_LOW;
          end else if (switch_mask[1]) begin
            mode_next = MODE_HIGH;
          end else if (switch_mask[2]) begin
            mode_next = MODE_TEMP;
          end
        end
        KIND_KEY: begin
          take = (mode == MODE_LOW) || (mode == MODE_HIGH);
        end
        default: begin
        end
      endcase
    end

    // Keypad entry: digits accumulate, star aborts, hash ends the entry and commits a value below the limit
    if (take) begin
      entry_active_next = 1'b1;
      entry_value_next  = base_value;
      if (key_code <= KEY_LAST_DIGIT) begin
        entry_value_next = (digit_value > ENTRY_WRAP_LIMIT) ? 14'd0 : digit_value[13:0];
      end else if (key_code == KEY_STAR) begin
        entry_active_next = 1'b0;
      end else if (key_code == KEY_HASH) begin
        entry_active_next = 1'b0;
        if (base_value < COMMIT_LIMIT) begin
          if (mode == MODE_LOW) begin
            low_limit_next = base_value[6:0];
          end else if (mode == MODE_HIGH) begin
            high_limit_next = base_value[6:0];
          end
        end
      end
    end
  end

  // Hysteresis on the updated values; frozen while entering
  assign temp_ext = {current_temp_next[9], current_temp_next};
  assign low_ext  = $signed({4'd0, low_limit_next});
  assign high_ext = $signed({4'd0, high_limit_next});

  always_comb begin
    valve_flag_next = valve_flag;
    pump_flag_next  = pump_flag;
    if (!entry_active_next) begin
      if (temp_ext < low_ext) begin
        valve_flag_next = 1'b1;
        pump_flag_next  = 1'b0;
      end else if (temp_ext > high_ext) begin
        valve_flag_next = 1'b0;
        pump_flag_next  = 1'b1;
      end
    end
  end

  // Build the result beat from the next state
  always_comb begin
    result.valve_open   = valve_flag_next;
    result.pump_running = pump_flag_next;
    result.view_mode    = mode_next;
    result.entering     = entry_active_next;
    if (entry_active_next) begin
      result.shown_value = $signed({1'b0, entry_value_next});
    end else begin
      case (mode_next)
        MODE_LOW:  result.shown_value = $signed({8'd0, low_limit_next});
        MODE_HIGH: result.shown_value = $signed({8'd0, high_limit_next});
        MODE_TEMP: result.shown_value = {{5{current_temp_next[9]}}, current_temp_next};
        default:   result.shown_value = 15'sd0;
      endcase
    end
  end

  // Commit the state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_TEMP;
      entry_active <= 1'b0;
      entry_value  <= 14'd0;
      low_limit    <= LOW_RESET;
      high_limit   <= HIGH_RESET;
      current_temp <= 10'sd0;
      valve_flag   <= 1'b1;
      pump_flag    <= 1'b0;
    end else if (beat) begin
      mode         <= mode_next;
      entry_active <= entry_active_next;
      entry_value  <= entry_value_next;
      low_limit    <= low_limit_next;
      high_limit   <= high_limit_next;
      current_temp <= current_temp_next;
      valve_flag   <= valve_flag_next;
      pump_flag    <= pump_flag_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/htke_outreg.sv -----
// ----------------------------------------------------------------------------
// htke_outreg
// Result register on the master side; takes a new beat whenever the
// register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module htke_outreg
  import htke_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire htke_result_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output htke_result_t      out_data
);

  // Free when empty or emptying this cycle
  assign in_ready = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Load the payload; hold it while stalled
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hysteresis_thermostat_keypad_entry.sv -----
// ----------------------------------------------------------------------------
// hysteresis_thermostat_keypad_entry
// Bang-bang thermostat with view modes and keypad-entered thresholds.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one event per beat: s_tuser holds the event kind
//   (sample, switch or key) and s_tdata the switch mask, key code and
//   signed temperature sample. Every event gives exactly one result beat
//   on the master side: shown value and valve/pump flags in m_tdata,
//   view mode and entry flag in m_tuser.
//   An accepted beat's result is registered and valid in the cycle after.
//   Throughput is one event per cycle while the result register is free,
//   set by the single-pass state update in the control logic.
//   When the receiver stalls, the result register holds its beat and
//   s_tready stays high only if that beat is taken in the same cycle.
//   Reset (rst, synchronous) empties the result register and returns the
//   state to temperature view, thresholds 23 and 26, temperature 0,
//   valve open and pump stopped.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_thermostat_keypad_entry
  import htke_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [2:0] switch_mask, [6:3] key_code, [16:7] sample, [23:17] zero
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [14:0] shown_value, [15] valve_open, [16] pump_running, [23:17] zero
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // [1:0] view_mode, [2] entering
  output logic [OUT_TUSER_W-1:0]      m_tuser
);

  logic         beat;
  htke_result_t result;
  htke_result_t held;

  assign beat = s_tvalid && s_tready;

  // Event logic and state
  htke_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .kind        (s_tuser[1:0]),
    .switch_mask (s_tdata[2:0]),
    .key_code    (s_tdata[6:3]),
    .sample      ($signed(s_tdata[16:7])),
    .result      (result)
  );

  // Result register
  htke_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (held)
  );

  // Pack the result beat
  assign m_tdata = {7'd0, held.pump_running, held.valve_open, held.shown_value};
  assign m_tuser = {held.entering, held.view_mode};

endmodule

`default_nettype wire

// ----- hdl/htke_checker.sv -----
// ----------------------------------------------------------------------------
// htke_checker
// Port-level checks on the thermostat block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hysteresis_thermostat_keypad_entry_defines.svh"

module htke_checker
  import htke_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [OUT_TUSER_W-1:0] m_tuser
);

  // A stalled result beat holds
  `HTKE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // Every accepted event produces a result beat next cycle
  `HTKE_ASSERT_NEXT(a_one_result, s_tvalid && s_tready, m_tvalid, "accepted event gave no result")

  // Valve and pump always oppose each other
  `HTKE_ASSERT_NOW(a_flags, m_tvalid, m_tdata[15] != m_tdata[16], "valve and pump flags agree")

  // Entry only runs in a threshold view
  `HTKE_ASSERT_NOW(a_entry_view, m_tvalid && m_tuser[2], m_tuser[1:0] == MODE_LOW || m_tuser[1:0] == MODE_HIGH, "entry outside a threshold view")

endmodule

bind hysteresis_thermostat_keypad_entry htke_checker u_htke_checker (.*);

`default_nettype wire

// ----- tb/hysteresis_thermostat_keypad_entry_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysteresis_thermostat_keypad_entry_tb
// Self-checking bench for the keypad-set thermostat. It streams sample,
// switch and key events into the block and keeps a shadow copy of the
// thermostat state. Each result beat is compared field by field with the
// view that the shadow copy expects. A directed set covers the corner cases
// and random sessions and noise events the rest, under three back-pressure mixes.
// ----------------------------------------------------------------------------

module hysteresis_thermostat_keypad_entry_tb;
  import htke_pkg::*;

  localparam int         STALL_LIMIT   = 2000;
  localparam int         DRAIN_CYCLES  = 4;
  localparam int         REPORT_LIMIT  = 10;
  localparam int         RANDOM_EVENTS = 950;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam logic [3:0] KEY_LETTER_A  = 4'd10;
  localparam logic [3:0] KEY_LETTER_D  = 4'd13;
  localparam logic [2:0] SW_NONE       = 3'b000;
  localparam logic [2:0] SW_LOW        = 3'b001;
  localparam logic [2:0] SW_HIGH       = 3'b010;
  localparam logic [2:0] SW_TEMP       = 3'b100;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  // Shadow thermostat state
  logic [1:0]        view_sel;
  logic              entry_on;
  logic [13:0]       entry_val;
  logic [6:0]        low_thr;
  logic [6:0]        high_thr;
  logic signed [9:0] cur_temp;
  logic              valve_on;
  logic              pump_on;

  htke_result_t expected_views[$];

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int n_events      = 0;
  int n_checked     = 0;
  int n_commits     = 0;
  int n_rejected    = 0;
  int error_count   = 0;
  int stall_cycles  = 0;

  hysteresis_thermostat_keypad_entry dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- shadow

  function automatic void reset_thermostat();
    view_sel  = MODE_TEMP;
    entry_on  = 1'b0;
    entry_val = '0;
    low_thr   = LOW_RESET;
    high_thr  = HIGH_RESET;
    cur_temp  = '0;
    valve_on  = 1'b1;
    pump_on   = 1'b0;
  endfunction

  // Apply one keypad key to an entry already in progress
  function automatic void take_keypad_key(logic [3:0] key);
    int acc;
    if (key <= KEY_LAST_DIGIT) begin
      acc = int'(entry_val) * 10 + int'(key);
      entry_val = (acc > int'(ENTRY_WRAP_LIMIT)) ? 14'd0 : 14'(acc);
    end else if (key == KEY_STAR) begin
      entry_on = 1'b0;
    end else if (key == KEY_HASH) begin
      entry_on = 1'b0;
      if (entry_val < COMMIT_LIMIT) begin
        if (view_sel == MODE_LOW) low_thr = entry_val[6:0];
        else if (view_sel == MODE_HIGH) high_thr = entry_val[6:0];
        n_commits++;
      end else begin
        n_rejected++;
      end
    end
  endfunction

  // Advance the shadow by one event and queue the view it should produce
  function automatic void advance_thermostat(logic [1:0] kind, logic [2:0] sw,
                                              logic [3:0] key,
                                              logic signed [9:0] sample);
    htke_result_t view;
    int           shown;
    if (entry_on) begin
      if (kind == KIND_KEY) take_keypad_key(key);
    end else if (kind == KIND_SAMPLE) begin
      if (view_sel == MODE_TEMP) cur_temp = sample;
    end else if (kind == KIND_SWITCH) begin
      if (sw[0]) view_sel = MODE_LOW;
      else if (sw[1]) view_sel = MODE_HIGH;
      else if (sw[2]) view_sel = MODE_TEMP;
    end else if (kind == KIND_KEY) begin
      if (view_sel == MODE_LOW || view_sel == MODE_HIGH) begin
        entry_on  = 1'b1;
        entry_val = '0;
        take_keypad_key(key);
      end
    end

    // Bang-bang control, frozen while a value is being keyed in
    if (!entry_on) begin
      if (int'(cur_temp) < int'(low_thr)) begin
        valve_on = 1'b1;
        pump_on  = 1'b0;
      end else if (int'(cur_temp) > int'(high_thr)) begin
        valve_on = 1'b0;
        pump_on  = 1'b1;
      end
    end

    if (entry_on) shown = int'(entry_val);
    else if (view_sel == MODE_LOW) shown = int'(low_thr);
    else if (view_sel == MODE_HIGH) shown = int'(high_thr);
    else if (view_sel == MODE_TEMP) shown = int'(cur_temp);
    else shown = 0;

    view.shown_value  = 15'(shown);
    view.valve_open   = valve_on;
    view.pump_running = pump_on;
    view.view_mode    = view_sel;
    view.entering     = entry_on;
    expected_views.push_back(view);
  endfunction

  // ---------------------------------------------------------------- driver

  // Send one event beat; idle the sender cycle by cycle at the set rate first
  task automatic send_event(input logic [1:0] kind, input logic [2:0] sw,
                            input logic [3:0] key, input logic signed [9:0] sample);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, sample, key, sw};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    advance_thermostat(kind, sw, key, sample);
    n_events++;
  endtask

  task automatic send_key(input logic [3:0] key);
    send_event(KIND_KEY, 3'($urandom), key, 10'($urandom));
  endtask

  task automatic send_switch(input logic [2:0] sw);
    send_event(KIND_SWITCH, sw, 4'($urandom), 10'($urandom));
  endtask

  task automatic send_sample(input logic signed [9:0] sample);
    send_event(KIND_SAMPLE, 3'($urandom), 4'($urandom), sample);
  endtask

  // Random receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------- checker

  task automatic note_error(input string what, input htke_result_t want,
                            input htke_result_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("[%0t] %s: expected shown=%0d valve=%0b pump=%0b mode=%0d entry=%0b,",
               $realtime, what, want.shown_value, want.valve_open,
               want.pump_running, want.view_mode, want.entering);
    if (error_count <= REPORT_LIMIT)
      $display("    got shown=%0d valve=%0b pump=%0b mode=%0d entry=%0b",
               got.shown_value, got.valve_open, got.pump_running,
               got.view_mode, got.entering);
  endtask

  // Compare each accepted result beat with the oldest expected view
  always @(posedge clk) begin : check_results
    htke_result_t got;
    htke_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.shown_value  = m_tdata[14:0];
      got.valve_open   = m_tdata[15];
      got.pump_running = m_tdata[16];
      got.view_mode    = m_tuser[1:0];
      got.entering     = m_tuser[2];
      if (expected_views.size() == 0) begin
        want = '0;
        note_error("result beat with nothing expected", want, got);
      end else begin
        want = expected_views.pop_front();
        n_checked++;
        if (got.shown_value !== want.shown_value ||
            got.valve_open !== want.valve_open ||
            got.pump_running !== want.pump_running ||
            got.view_mode !== want.view_mode ||
            got.entering !== want.entering)
          note_error("result mismatch", want, got);
      end
    end
  end

  // Abort when neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_views.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // Extreme samples in temperature view, plus the unused kind
  task automatic test_sample_hysteresis();
    send_sample(10'sd511);
    send_sample(-10'sd512);
    send_sample(10'sd24);
    send_event(KIND_UNUSED, 3'b111, KEY_HASH, 10'sd300);
  endtask

  // Empty mask holds, lowest set switch wins, samples ignored off temp view
  task automatic test_switch_select();
    send_switch(SW_NONE);
    send_switch(3'b111);
    send_sample(10'sd100);
  endtask

  // Letter as first key, accumulate to 9999, then wrap to zero
  task automatic test_keypad_entry();
    send_key(KEY_LETTER_A);
    repeat (4) send_key(4'd9);
    send_key(4'd9);
  endtask

  // Switches, samples and letters are ignored mid-entry
  task automatic test_entry_freeze();
    send_switch(SW_LOW);
    send_sample(-10'sd5);
    send_key(KEY_LETTER_D);
  endtask

  // Commit just below the limit, first-key hash, commit refused at the limit, first-key star
  task automatic test_commit_limits();
    send_key(4'd1);
    send_key(4'd2);
    send_key(4'd7);
    send_key(KEY_HASH);
    send_switch(3'b110);
    send_key(KEY_HASH);
    send_key(4'd1);
    send_key(4'd2);
    send_key(4'd8);
    send_key(KEY_HASH);
    send_key(KEY_STAR);
  endtask

  // Keys in temperature view do nothing
  task automatic test_ignored_events();
    send_switch(SW_TEMP);
    send_key(4'd5);
  endtask

  // Any event at all, kind 3 now and then
  task automatic send_noise();
    logic [1:0] kind;
    kind = ($urandom_range(0, 29) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
    send_event(kind, 3'($urandom), 4'($urandom), 10'($urandom));
  endtask

  // One threshold entry: pick a view, key a number, then usually terminate with hash or star
  task automatic keypad_session();
    int value;
    int digits[$];
    int pick;
    send_switch($urandom_range(0, 1) ? {2'($urandom), 1'b1} : {1'($urandom), SW_HIGH[1:0]});
    if ($urandom_range(0, 6) == 0) send_key(4'($urandom_range(KEY_LETTER_A, KEY_LETTER_D)));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat (5) digits.push_back($urandom_range(1, 9));
    end else if (pick > 1) begin
      value = $urandom_range(0, 160);
      do begin
        digits.push_front(value % 10);
        value = value / 10;
      end while (value != 0);
      if ($urandom_range(0, 7) == 0) digits.push_front(0);
    end
    foreach (digits[i]) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_key(4'(digits[i]));
    end
    pick = $urandom_range(0, 19);
    if (pick < 15) send_key(KEY_HASH);
    else if (pick < 18) send_key(KEY_STAR);
  endtask

  // Mostly temperature view, with samples mostly around either threshold
  task automatic temperature_session();
    int base;
    send_switch($urandom_range(0, 3) == 0 ? 3'($urandom) : SW_TEMP);
    repeat ($urandom_range(2, 6)) begin
      base = $urandom_range(0, 1) ? int'(low_thr) : int'(high_thr);
      if ($urandom_range(0, 4) == 0) send_sample(10'($urandom));
      else send_sample(10'(base + $urandom_range(0, 6) - 3));
    end
  endtask

  task automatic test_random_sessions(input int target);
    int pick;
    while (n_events < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) keypad_session();
      else if (pick < 75) temperature_session();
      else send_noise();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int base;
    reset_thermostat();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Receiver mostly stalled
    tx_idle_pct = 7;
    rx_idle_pct = 84;
    test_sample_hysteresis();
    test_switch_select();
    test_keypad_entry();
    test_entry_freeze();
    test_commit_limits();
    test_ignored_events();
    base = n_events;
    test_random_sessions(base + RANDOM_EVENTS / 3);

    // Sender mostly idle
    tx_idle_pct = 84;
    rx_idle_pct = 7;
    test_random_sessions(base + 2 * RANDOM_EVENTS / 3);

    // Full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_sessions(base + RANDOM_EVENTS);
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d events over three back-pressure mixes, %0d results checked",
             n_events, n_checked);
    $display("Threshold commits taken %0d, refused at the limit %0d, errors %0d",
             n_commits, n_rejected, error_count);
    if (error_count == 0 && expected_views.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
